/* hw/rtl/tee_pkg.sv */
// Shared types, constants and register codes for the trigger epoch extractor.
`timescale 1ns / 1ps

package tee_pkg;

    // Default build parameters
    localparam int DELAY_DEPTH_DEF  = 1024;
    localparam int MAX_OPEN_DEF     = 8;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int EVENT_W   = 16;
    localparam int PRE_W     = 10;
    localparam int POST_W    = 16;
    localparam int OFFSET_W  = 17;
    localparam int TAG_W     = 8;
    localparam int SEEN_W    = 11;
    localparam int ENABLE_W  = 4;
    localparam int OUT_SAMP_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Epoch table entry: tag above offset
    localparam int EPOCH_W = TAG_W + OFFSET_W;

    // Register reset values
    localparam logic [PRE_W-1:0]  PRE_RESET  = PRE_W'(1);
    localparam logic [POST_W-1:0] POST_RESET = POST_W'(1);

    // Saturation point of the sample counter
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE    = 3'd0,
        CFG_POST   = 3'd1,
        CFG_CODE_A = 3'd2,
        CFG_CODE_B = 3'd3,
        CFG_CODE_C = 3'd4,
        CFG_CODE_D = 3'd5,
        CFG_ENABLE = 3'd6
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

/* hw/rtl/tee_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read-before-write on the registered output
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/trigger_epoch_extractor_core.sv */
// Trigger epoch extractor top level: history delay line, epoch table and sequencer.
`timescale 1ns / 1ps

// Each item passes through these steps: the sequencer accepts it and writes the
// history memory, then fetches the delayed sample, then gives one result per
// cycle for each of the N epochs open after the item's trigger check (0 to
// MAX_OPEN) as it walks the epoch table memory through its single read port,
// while the result register is not held by m_ready. Items that leave no epoch
// open end at the accept step. The history memory needs no clearing pass; the
// block is ready right after reset. Configuration is written through cfg_* only
// while no item is in flight; the user must keep to this, the block does not enforce it.
module trigger_epoch_extractor_core #(
    parameter int DELAY_DEPTH  = tee_pkg::DELAY_DEPTH_DEF,
    parameter int MAX_OPEN     = tee_pkg::MAX_OPEN_DEF,
    parameter int SAMPLE_WIDTH = tee_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tee_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tee_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [31:0]                   s_sample_in,
    input  logic [tee_pkg::EVENT_W-1:0]          s_event_in,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tee_pkg::TAG_W-1:0]            m_epoch_tag,
    output logic [tee_pkg::OFFSET_W-1:0]         m_sample_offset,
    output logic signed [31:0]                   m_sample_out,
    output logic [tee_pkg::EVENT_W-1:0]          m_event_out,
    output logic                                 m_epoch_end,
    output logic                                 m_run_last,
    output logic                                 m_overflow_seen
);

    localparam int DAW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int OAW = (MAX_OPEN > 1) ? $clog2(MAX_OPEN) : 1;
    localparam int CW  = $clog2(MAX_OPEN + 1);
    localparam int HW  = SAMPLE_WIDTH + tee_pkg::EVENT_W;
    localparam int EW  = tee_pkg::EPOCH_W;
    localparam int OW  = tee_pkg::OFFSET_W;
    localparam logic [31:0] DEPTH_M1 = 32'(DELAY_DEPTH - 1);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tee_pkg::state_t state_reg, state_next;

    logic [tee_pkg::PRE_W-1:0]    pre_reg, pre_next;
    logic [tee_pkg::POST_W-1:0]   post_reg, post_next;
    logic [tee_pkg::EVENT_W-1:0]  code_a_reg, code_a_next;
    logic [tee_pkg::EVENT_W-1:0]  code_b_reg, code_b_next;
    logic [tee_pkg::EVENT_W-1:0]  code_c_reg, code_c_next;
    logic [tee_pkg::EVENT_W-1:0]  code_d_reg, code_d_next;
    logic [tee_pkg::ENABLE_W-1:0] enable_reg, enable_next;

    logic [DAW-1:0]               wp_reg, wp_next;
    logic [tee_pkg::SEEN_W-1:0]   seen_reg, seen_next;
    logic [tee_pkg::EVENT_W-1:0]  prev_ev_reg, prev_ev_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [tee_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic                         overflow_reg, overflow_next;

    logic [CW-1:0]                n_reg, n_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                k_reg, k_next;
    logic                         fwd_reg, fwd_next;
    logic [HW-1:0]                fwd_data_reg, fwd_data_next;
    logic [HW-1:0]                entry_reg, entry_next;

    logic                         m_valid_reg, m_valid_next;
    logic [tee_pkg::TAG_W-1:0]    m_tag_reg, m_tag_next;
    logic [OW-1:0]                m_off_reg, m_off_next;
    logic [31:0]                  m_samp_reg, m_samp_next;
    logic [tee_pkg::EVENT_W-1:0]  m_ev_reg, m_ev_next;
    logic                         m_end_reg, m_end_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_ovf_reg, m_ovf_next;

    // ---------------------------------------------------------------
    // Memory ports
    // ---------------------------------------------------------------
    logic           hist_we, hist_re;
    logic [DAW-1:0] hist_raddr;
    logic [HW-1:0]  hist_wdata, hist_rdata;

    logic           tbl_we, tbl_re;
    logic [OAW-1:0] tbl_waddr, tbl_raddr;
    logic [EW-1:0]  tbl_wdata, tbl_rdata;

    tee_ram #(
        .WIDTH (HW),
        .DEPTH (DELAY_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (wp_reg),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    tee_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_OPEN)
    ) u_epoch_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // ---------------------------------------------------------------
    // Shared combinational terms
    // ---------------------------------------------------------------
    logic                        s_take;
    logic [tee_pkg::PRE_W-1:0]   pre_eff;
    logic [DAW:0]                rd_diff;
    logic [DAW:0]                rd_wrap;
    logic [OW-1:0]               last_off;
    logic                        trig_hit;
    logic                        trig_take;
    logic                        tbl_full;
    logic                        insert;
    logic [CW-1:0]               n_acc;
    logic signed [63:0]          s_ext;
    logic [OW-1:0]               ep_off;
    logic [tee_pkg::TAG_W-1:0]   ep_tag;
    logic                        ep_end;
    logic [CW-1:0]               idx_inc;
    logic                        more;
    logic                        out_free;
    logic                        out_load;
    logic signed [SAMPLE_WIDTH-1:0] hist_samp;
    logic signed [63:0]          hist_samp_ext;

    assign s_take = s_valid && s_ready;

    // Pre window clamped to the history depth
    assign pre_eff = (32'(pre_reg) > DEPTH_M1) ? DEPTH_M1[tee_pkg::PRE_W-1:0] : pre_reg;

    // Delayed read address, modulo the depth
    assign rd_diff = {1'b0, wp_reg} - (DAW+1)'(pre_eff);
    assign rd_wrap = rd_diff + (DAW+1)'(DELAY_DEPTH);
    assign hist_raddr = rd_diff[DAW] ? rd_wrap[DAW-1:0] : rd_diff[DAW-1:0];

    assign last_off = OW'(pre_eff) + OW'(post_reg);

    // Edge-qualified trigger match on any enabled code
    always_comb begin
        trig_hit = 1'b0;
        if (s_event_in != prev_ev_reg) begin
            if (enable_reg[0] && s_event_in == code_a_reg) trig_hit = 1'b1;
            if (enable_reg[1] && s_event_in == code_b_reg) trig_hit = 1'b1;
            if (enable_reg[2] && s_event_in == code_c_reg) trig_hit = 1'b1;
            if (enable_reg[3] && s_event_in == code_d_reg) trig_hit = 1'b1;
        end
    end

    assign trig_take = trig_hit && (seen_reg >= tee_pkg::SEEN_W'(pre_eff));
    assign tbl_full  = (count_reg == CW'(MAX_OPEN));
    assign insert    = trig_take && !tbl_full;
    assign n_acc     = count_reg + CW'(insert);

    assign s_ext      = 64'(s_sample_in);
    assign hist_wdata = {s_ext[SAMPLE_WIDTH-1:0], s_event_in};

    // Epoch entry under the sequencer
    assign ep_off  = tbl_rdata[OW-1:0];
    assign ep_tag  = tbl_rdata[EW-1:OW];
    assign ep_end  = (ep_off >= last_off);
    assign idx_inc = idx_reg + CW'(1);
    assign more    = (idx_inc != n_reg);

    assign out_free = !m_valid_reg || m_ready;

    assign hist_samp     = entry_reg[HW-1:tee_pkg::EVENT_W];
    assign hist_samp_ext = 64'(hist_samp);

    // ---------------------------------------------------------------
    // Sequencer next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tee_pkg::ST_IDLE: begin
                if (s_valid && n_acc != '0) begin
                    state_next = tee_pkg::ST_FETCH;
                end
            end
            tee_pkg::ST_FETCH: begin
                state_next = tee_pkg::ST_EMIT;
            end
            tee_pkg::ST_EMIT: begin
                if (out_free && !more) begin
                    state_next = tee_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tee_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs: handshake and memory strobes
    // ---------------------------------------------------------------
    always_comb begin
        s_ready   = 1'b0;
        hist_we   = 1'b0;
        hist_re   = 1'b0;
        tbl_we    = 1'b0;
        tbl_re    = 1'b0;
        tbl_waddr = count_reg[OAW-1:0];
        tbl_wdata = {tag_reg, OW'(0)};
        tbl_raddr = idx_reg[OAW-1:0];
        out_load  = 1'b0;
        unique case (state_reg)
            tee_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                hist_we = s_valid;
                hist_re = s_valid;
                tbl_we  = s_valid && insert;
            end
            tee_pkg::ST_FETCH: begin
                tbl_re = 1'b1;
            end
            tee_pkg::ST_EMIT: begin
                out_load  = out_free;
                tbl_we    = out_free && !ep_end;
                tbl_waddr = k_reg[OAW-1:0];
                tbl_wdata = {ep_tag, ep_off + OW'(1)};
                tbl_re    = out_free && more;
                tbl_raddr = idx_inc[OAW-1:0];
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Datapath next values
    // ---------------------------------------------------------------
    always_comb begin
        pre_next      = pre_reg;
        post_next     = post_reg;
        code_a_next   = code_a_reg;
        code_b_next   = code_b_reg;
        code_c_next   = code_c_reg;
        code_d_next   = code_d_reg;
        enable_next   = enable_reg;
        wp_next       = wp_reg;
        seen_next     = seen_reg;
        prev_ev_next  = prev_ev_reg;
        count_next    = count_reg;
        tag_next      = tag_reg;
        overflow_next = overflow_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        fwd_next      = fwd_reg;
        fwd_data_next = fwd_data_reg;
        entry_next    = entry_reg;
        m_valid_next  = m_valid_reg;
        m_tag_next    = m_tag_reg;
        m_off_next    = m_off_reg;
        m_samp_next   = m_samp_reg;
        m_ev_next     = m_ev_reg;
        m_end_next    = m_end_reg;
        m_last_next   = m_last_reg;
        m_ovf_next    = m_ovf_reg;

        // Configuration writes
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tee_pkg::CFG_PRE:    pre_next    = cfg_data[tee_pkg::PRE_W-1:0];
                tee_pkg::CFG_POST:   post_next   = cfg_data[tee_pkg::POST_W-1:0];
                tee_pkg::CFG_CODE_A: code_a_next = cfg_data;
                tee_pkg::CFG_CODE_B: code_b_next = cfg_data;
                tee_pkg::CFG_CODE_C: code_c_next = cfg_data;
                tee_pkg::CFG_CODE_D: code_d_next = cfg_data;
                tee_pkg::CFG_ENABLE: enable_next = cfg_data[tee_pkg::ENABLE_W-1:0];
                default: begin
                    pre_next = pre_reg;
                end
            endcase
        end

        // Output register drains
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Item accept: history write, trigger check, table insert
        if (s_take) begin
            if (trig_take && tbl_full) begin
                overflow_next = 1'b1;
            end
            if (insert) begin
                tag_next = tag_reg + tee_pkg::TAG_W'(1);
            end
            n_next        = n_acc;
            count_next    = n_acc;
            idx_next      = '0;
            k_next        = '0;
            fwd_next      = (pre_eff == '0);
            fwd_data_next = hist_wdata;
            prev_ev_next  = s_event_in;
            if (seen_reg != tee_pkg::SEEN_MAX) begin
                seen_next = seen_reg + tee_pkg::SEEN_W'(1);
            end
            wp_next = (32'(wp_reg) == DEPTH_M1) ? '0 : wp_reg + DAW'(1);
        end

        // Delayed sample lands; zero delay takes the word just written
        if (state_reg == tee_pkg::ST_FETCH) begin
            entry_next = fwd_reg ? fwd_data_reg : hist_rdata;
        end

        // One epoch emits and is written back compacted unless it ended
        if (out_load) begin
            m_valid_next = 1'b1;
            m_tag_next   = ep_tag;
            m_off_next   = ep_off;
            m_samp_next  = hist_samp_ext[31:0];
            m_ev_next    = entry_reg[tee_pkg::EVENT_W-1:0];
            m_end_next   = ep_end;
            m_last_next  = !more;
            m_ovf_next   = overflow_reg;
            idx_next     = idx_inc;
            k_next       = k_reg + CW'(!ep_end);
            if (!more) begin
                count_next = k_reg + CW'(!ep_end);
            end
        end
    end

    // ---------------------------------------------------------------
    // Register update
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tee_pkg::ST_IDLE;
            pre_reg      <= tee_pkg::PRE_RESET;
            post_reg     <= tee_pkg::POST_RESET;
            code_a_reg   <= '0;
            code_b_reg   <= '0;
            code_c_reg   <= '0;
            code_d_reg   <= '0;
            enable_reg   <= '0;
            wp_reg       <= '0;
            seen_reg     <= '0;
            prev_ev_reg  <= '0;
            count_reg    <= '0;
            tag_reg      <= '0;
            overflow_reg <= 1'b0;
            n_reg        <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pre_reg      <= pre_next;
            post_reg     <= post_next;
            code_a_reg   <= code_a_next;
            code_b_reg   <= code_b_next;
            code_c_reg   <= code_c_next;
            code_d_reg   <= code_d_next;
            enable_reg   <= enable_next;
            wp_reg       <= wp_next;
            seen_reg     <= seen_next;
            prev_ev_reg  <= prev_ev_next;
            count_reg    <= count_next;
            tag_reg      <= tag_next;
            overflow_reg <= overflow_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            k_reg        <= k_next;
            fwd_reg      <= fwd_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        fwd_data_reg <= fwd_data_next;
        entry_reg    <= entry_next;
        m_tag_reg    <= m_tag_next;
        m_off_reg    <= m_off_next;
        m_samp_reg   <= m_samp_next;
        m_ev_reg     <= m_ev_next;
        m_end_reg    <= m_end_next;
        m_last_reg   <= m_last_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_epoch_tag     = m_tag_reg;
    assign m_sample_offset = m_off_reg;
    assign m_sample_out    = m_samp_reg;
    assign m_event_out     = m_ev_reg;
    assign m_epoch_end     = m_end_reg;
    assign m_run_last      = m_last_reg;
    assign m_overflow_seen = m_ovf_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // open epoch count never exceeds the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_OPEN))
        else $error("epoch count beyond table size");

    // overflow flag is sticky
    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    // compaction write never lands on the entry being read ahead
    a_tbl_no_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tee_pkg::ST_EMIT && tbl_we && tbl_re) |-> (tbl_waddr != tbl_raddr))
        else $error("epoch table read and write collide");

    // write-back slot trails the read slot while emitting
    a_k_trails: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tee_pkg::ST_EMIT) |-> (k_reg <= idx_reg && idx_reg < n_reg))
        else $error("epoch walk indexes out of order");

endmodule
